@@ src/tovm_pkg.sv @@
package tovm_pkg;

  typedef enum logic [2:0] {
    FN_MOV = 3'd0,
    FN_ADD = 3'd1,
    FN_MUL = 3'd2,
    FN_SUB = 3'd3,
    FN_DIV = 3'd4,
    FN_AND = 3'd5,
    FN_OR  = 3'd6,
    FN_NOT = 3'd7
  } func_e;

  typedef enum logic [1:0] {
    MD_REG  = 2'd0,
    MD_DIR  = 2'd1,
    MD_IND  = 2'd2,
    MD_IMM  = 2'd3
  } mode_e;

  localparam logic [1:0] RemReg = 2'd3;

  typedef struct packed {
    logic [2:0]  func;
    logic [1:0]  dest_mode;
    logic [30:0] dest_operand;
    logic [1:0]  src_mode;
    logic [30:0] src_operand;
  } req_t;

  typedef struct packed {
    logic signed [31:0] reg_a;
    logic signed [31:0] reg_b;
    logic signed [31:0] reg_c;
    logic signed [31:0] reg_d;
    logic               divide_by_zero;
  } rsp_t;

  // Datapath steps chosen by the controller.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_MEM_RD_DST,
    CMD_PTR_DST,
    CMD_LATCH_DST,
    CMD_MEM_RD_SRC,
    CMD_PTR_SRC,
    CMD_LATCH_SRC,
    CMD_ARITH_START,
    CMD_ITER,
    CMD_WRITE,
    CMD_CLEAR
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
  } ctl_t;

  typedef struct packed {
    logic dst_is_ind;
    logic src_is_ind;
    logic iter_done;
    logic clear_done;
  } sts_t;

endpackage

@@ src/tovm_ctrl.sv @@
module tovm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  tovm_pkg::sts_t sts_i,
  output tovm_pkg::ctl_t ctl_o
);
  import tovm_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DRD, S_DPTR, S_DRD2, S_SRD, S_SPTR, S_SRD2,
    S_SLAT, S_START, S_ITER, S_WRITE, S_OUT
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  // Command for the datapath from the current state.
  always_comb begin
    ctl_o.cmd = CMD_NONE;
    unique case (state_q)
      S_CLEAR: ctl_o.cmd = CMD_CLEAR;
      S_IDLE:  ctl_o.cmd = in_valid_i ? CMD_LOAD : CMD_NONE;
      S_DRD:   ctl_o.cmd = CMD_MEM_RD_DST;
      S_DPTR:  ctl_o.cmd = CMD_PTR_DST;
      S_DRD2:  ctl_o.cmd = CMD_LATCH_DST;
      S_SRD:   ctl_o.cmd = CMD_MEM_RD_SRC;
      S_SPTR:  ctl_o.cmd = CMD_PTR_SRC;
      S_SRD2:  ctl_o.cmd = CMD_NONE;
      S_SLAT:  ctl_o.cmd = CMD_LATCH_SRC;
      S_START: ctl_o.cmd = CMD_ARITH_START;
      S_ITER:  ctl_o.cmd = CMD_ITER;
      S_WRITE: ctl_o.cmd = CMD_WRITE;
      S_OUT:   ctl_o.cmd = CMD_NONE;
      default: ctl_o.cmd = CMD_NONE;
    endcase
  end

  // Sequence one instruction; the result register waits for the receiver.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_CLEAR: if (sts_i.clear_done) state_q <= S_IDLE;
        S_IDLE:  if (in_valid_i) state_q <= S_DRD;
        S_DRD:   state_q <= sts_i.dst_is_ind ? S_DPTR : S_DRD2;
        S_DPTR:  state_q <= S_DRD2;
        S_DRD2:  state_q <= S_SRD;
        S_SRD:   state_q <= sts_i.src_is_ind ? S_SPTR : S_SRD2;
        S_SPTR:  state_q <= S_SRD2;
        S_SRD2:  state_q <= S_SLAT;
        S_SLAT:  state_q <= S_START;
        S_START: state_q <= S_ITER;
        S_ITER:  if (sts_i.iter_done) state_q <= S_WRITE;
        S_WRITE: begin
          state_q     <= S_OUT;
          out_valid_q <= 1'b1;
        end
        S_OUT: if (!out_stall_i) begin
          state_q     <= S_IDLE;
          out_valid_q <= 1'b0;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

@@ src/tovm_dp.sv @@
module tovm_dp #(
  parameter int MEM_WORDS = 512
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tovm_pkg::req_t in_data_i,
  input  tovm_pkg::ctl_t ctl_i,
  output tovm_pkg::sts_t sts_o,
  output tovm_pkg::rsp_t out_data_o
);
  import tovm_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);

  logic [31:0] mem [MEM_WORDS];
  logic [31:0] gpr_q [4];
  req_t        req_q;
  logic [AW-1:0] daddr_q, raddr_d, clr_q;
  logic [31:0] rdata_q, d_q, s_q;
  logic        dz_q, dz_d;
  // Shared shift unit for multiply and divide.
  logic [31:0] acc_q, opa_q, opb_q;
  logic [31:0] rem_q;
  logic [5:0]  cnt_q;
  logic        na_q, nb_q;
  logic        we;
  logic [AW-1:0] waddr;
  logic [31:0] wdata, res, remv, quo;
  logic [32:0] trial;
  logic        mem_rd;
  logic        dst_is_mem;
  logic        dst_is_rem;

  // Address modulo depth: depth is taken as a power of two.
  function automatic logic [AW-1:0] wrap(input logic [31:0] v);
    return v[AW-1:0];
  endfunction

  assign dst_is_mem = (req_q.dest_mode == MD_DIR) || (req_q.dest_mode == MD_IND);
  assign dst_is_rem = (req_q.dest_mode == MD_REG) && (req_q.dest_operand[1:0] == RemReg);
  assign sts_o.dst_is_ind = (req_q.dest_mode == MD_IND);
  assign sts_o.src_is_ind = (req_q.src_mode == MD_IND);
  assign sts_o.iter_done  = (cnt_q == 6'd0);
  assign sts_o.clear_done = (clr_q == AW'(MEM_WORDS - 1));

  // Read address selection.
  always_comb begin
    raddr_d = daddr_q;
    mem_rd  = 1'b1;
    case (ctl_i.cmd) inside
      CMD_MEM_RD_DST: raddr_d = wrap({1'b0, req_q.dest_operand});
      CMD_PTR_DST:    raddr_d = wrap(rdata_q);
      CMD_LATCH_DST, CMD_MEM_RD_SRC: raddr_d = wrap({1'b0, req_q.src_operand});
      CMD_PTR_SRC:    raddr_d = wrap(rdata_q);
      default:        mem_rd  = 1'b0;
    endcase
  end

  assign trial = {1'b0, rem_q[30:0], opa_q[31]} - {1'b0, opb_q};
  assign quo   = (na_q != nb_q) ? (32'd0 - acc_q) : acc_q;
  assign remv  = na_q ? (32'd0 - rem_q) : rem_q;

  // Final result of the operation.
  always_comb begin
    res = s_q;
    case (func_e'(req_q.func))
      FN_MOV: res = s_q;
      FN_ADD: res = d_q + s_q;
      FN_MUL: res = acc_q;
      FN_SUB: res = d_q - s_q;
      FN_DIV: res = quo;
      FN_AND: res = d_q & s_q;
      FN_OR:  res = d_q | s_q;
      default: res = ~d_q;
    endcase
  end

  assign dz_d  = (req_q.func == FN_DIV) && (s_q == 32'd0);
  assign we    = (ctl_i.cmd == CMD_CLEAR) ||
                 ((ctl_i.cmd == CMD_WRITE) && !dz_d && dst_is_mem);
  assign waddr = (ctl_i.cmd == CMD_CLEAR) ? clr_q : daddr_q;
  assign wdata = (ctl_i.cmd == CMD_CLEAR) ? 32'd0 : res;

  // Data memory, one write and one registered read.
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (mem_rd) rdata_q <= mem[raddr_d];
  end

  // Operand fetch, iteration and write-back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) gpr_q[i] <= '0;
      clr_q   <= '0;
      cnt_q   <= '0;
      dz_q    <= 1'b0;
      req_q   <= '0;
      daddr_q <= '0;
      d_q     <= '0;
      s_q     <= '0;
      acc_q   <= '0;
      opa_q   <= '0;
      opb_q   <= '0;
      rem_q   <= '0;
      na_q    <= 1'b0;
      nb_q    <= 1'b0;
    end else begin
      case (ctl_i.cmd)
        CMD_CLEAR: clr_q <= clr_q + AW'(1);
        CMD_LOAD:  req_q <= in_data_i;
        // Indirect destination address comes from the pointer word.
        CMD_PTR_DST: daddr_q <= wrap(rdata_q);
        CMD_LATCH_DST: begin
          // Destination word was read in the previous cycle.
          daddr_q <= sts_o.dst_is_ind ? daddr_q : wrap({1'b0, req_q.dest_operand});
          case (mode_e'(req_q.dest_mode))
            MD_REG: d_q <= gpr_q[req_q.dest_operand[1:0]];
            MD_IMM: d_q <= {1'b0, req_q.dest_operand};
            default: d_q <= rdata_q;
          endcase
        end
        CMD_LATCH_SRC: begin
          case (mode_e'(req_q.src_mode))
            MD_REG: s_q <= gpr_q[req_q.src_operand[1:0]];
            MD_IMM: s_q <= {1'b0, req_q.src_operand};
            default: s_q <= rdata_q;
          endcase
        end
        CMD_ARITH_START: begin
          cnt_q <= 6'd32;
          rem_q <= '0;
          acc_q <= '0;
          na_q  <= d_q[31];
          nb_q  <= s_q[31];
          if (req_q.func == FN_DIV) begin
            opa_q <= d_q[31] ? (32'd0 - d_q) : d_q;
            opb_q <= s_q[31] ? (32'd0 - s_q) : s_q;
          end else begin
            opa_q <= d_q;
            opb_q <= s_q;
          end
        end
        CMD_ITER: if (cnt_q != 6'd0) begin
          cnt_q <= cnt_q - 6'd1;
          if (req_q.func == FN_DIV) begin
            opa_q <= {opa_q[30:0], 1'b0};
            if (!trial[32]) begin
              rem_q <= trial[31:0];
              acc_q <= {acc_q[30:0], 1'b1};
            end else begin
              rem_q <= {rem_q[30:0], opa_q[31]};
              acc_q <= {acc_q[30:0], 1'b0};
            end
          end else begin
            // Shift-add multiply, low 32 bits.
            if (opb_q[0]) acc_q <= acc_q + opa_q;
            opa_q <= {opa_q[30:0], 1'b0};
            opb_q <= {1'b0, opb_q[31:1]};
          end
        end
        CMD_WRITE: begin
          dz_q <= dz_d;
          if (!dz_d) begin
            // The quotient takes precedence when the destination is the remainder register.
            if ((req_q.func == FN_DIV) && !dst_is_rem) gpr_q[RemReg] <= remv;
            if (req_q.dest_mode == MD_REG) gpr_q[req_q.dest_operand[1:0]] <= res;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_data_o.reg_a = gpr_q[0];
  assign out_data_o.reg_b = gpr_q[1];
  assign out_data_o.reg_c = gpr_q[2];
  assign out_data_o.reg_d = gpr_q[3];
  assign out_data_o.divide_by_zero = dz_q;
endmodule

@@ src/two_operand_vm_execute.sv @@
// Executes one decoded two-operand instruction per request.
// Input channel: in_valid_i / in_stall_o with payload in_data_i.
// Output channel: out_valid_o / out_stall_i with payload out_data_o, which
// shows all four registers and the divide-by-zero flag after the instruction.
// One instruction is in flight at a time. Each instruction goes through up to
// four dependent memory reads for the operands, 32 steps of the shared
// shift-add / shift-subtract unit, and a write-back step. The memory port
// allows one read and one write a cycle. A new request is taken in the cycle
// after the result is accepted.
// After reset the data memory is swept to zero, one word a cycle, until every
// word is cleared; in_stall_o stays high during the sweep.
// The result register holds while out_stall_i is high, and no new request
// is taken until the result has been accepted.
// MEM_WORDS must be a power of two.
module two_operand_vm_execute #(
  parameter int MEM_WORDS = 512
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  tovm_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output tovm_pkg::rsp_t out_data_o
);
  import tovm_pkg::*;

  ctl_t ctl;
  sts_t sts;

  tovm_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .ctl_o(ctl)
  );

  tovm_dp #(.MEM_WORDS(MEM_WORDS)) u_dp (
    .clk_i, .rst_ni, .in_data_i, .ctl_i(ctl), .sts_o(sts), .out_data_o
  );
endmodule

@@ src/tovm_checker.sv @@
module tovm_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input tovm_pkg::rsp_t out_data_o
);
  // No new request is taken while a result waits.
  a_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("request taken with result pending");
  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");
  // An accepted request never yields a result on the next edge.
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !out_valid_o) else $error("result too early");
endmodule

bind two_operand_vm_execute tovm_checker u_chk (.*);

@@ test/tb_two_operand_vm_execute.sv @@
`timescale 1ns / 100ps

module tb_two_operand_vm_execute;
  import tovm_pkg::*;

  localparam int MemWords = 512;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  req_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  rsp_t out_data_o;

  two_operand_vm_execute #(.MEM_WORDS(MemWords)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Shadow machine state.
  logic [31:0] vm_regs [4];
  logic [31:0] vm_mem [MemWords];

  req_t pending_requests[$];
  rsp_t expected_states[$];
  int   error_count;
  int   results_seen;
  int   queued_count;
  int   send_idle_pct;
  int   recv_idle_pct;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Resolve an operand: kind 0 register, 1 memory, 2 immediate.
  task automatic locate_operand(input logic [1:0] mode, input logic [30:0] opnd,
                                output int kind, output logic [31:0] where);
    case (mode_e'(mode))
      MD_REG: begin
        kind = 0;
        where = {30'd0, opnd[1:0]};
      end
      MD_DIR: begin
        kind = 1;
        where = {1'b0, opnd} % MemWords;
      end
      MD_IND: begin
        kind = 1;
        where = vm_mem[{1'b0, opnd} % MemWords] % MemWords;
      end
      default: begin
        kind = 2;
        where = {1'b0, opnd};
      end
    endcase
  endtask

  function automatic logic [31:0] read_operand(int kind, logic [31:0] where);
    if (kind == 0) return vm_regs[where[1:0]];
    if (kind == 1) return vm_mem[where];
    return where;
  endfunction

  // Execute one instruction on the shadow state and return the visible state.
  task automatic execute_instruction(input req_t rq, output rsp_t rs);
    int dk, sk;
    logic [31:0] dw, sw, d, s, r, ua, ub, q, m;
    logic dz;
    locate_operand(rq.dest_mode, rq.dest_operand, dk, dw);
    locate_operand(rq.src_mode, rq.src_operand, sk, sw);
    d = read_operand(dk, dw);
    s = read_operand(sk, sw);
    dz = 1'b0;
    r = '0;
    case (func_e'(rq.func))
      FN_MOV: r = s;
      FN_ADD: r = d + s;
      FN_MUL: r = d * s;
      FN_SUB: r = d - s;
      FN_DIV: begin
        if (s == 0) begin
          dz = 1'b1;
        end else begin
          ua = d[31] ? -d : d;
          ub = s[31] ? -s : s;
          q = ua / ub;
          m = ua % ub;
          if (d[31] != s[31]) q = -q;
          if (d[31]) m = -m;
          vm_regs[RemReg] = m;
          r = q;
        end
      end
      FN_AND: r = d & s;
      FN_OR:  r = d | s;
      default: r = ~d;
    endcase
    if (!dz) begin
      if (dk == 0) vm_regs[dw[1:0]] = r;
      else if (dk == 1) vm_mem[dw] = r;
    end
    rs.reg_a = vm_regs[0];
    rs.reg_b = vm_regs[1];
    rs.reg_c = vm_regs[2];
    rs.reg_d = vm_regs[3];
    rs.divide_by_zero = dz;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR %0t: %s got %h expected %h", $time, what, got, want);
    error_count++;
  endtask

  function automatic req_t make_request(func_e fn, mode_e dm, logic [30:0] dop,
                                        mode_e sm, logic [30:0] sop);
    req_t rq;
    rq.func = fn;
    rq.dest_mode = dm;
    rq.dest_operand = dop;
    rq.src_mode = sm;
    rq.src_operand = sop;
    return rq;
  endfunction

  // Operands mostly hit a small window of memory so pointers chain.
  function automatic logic [30:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return 31'($urandom);
      1: return 31'h7fff_ffff - 31'($urandom_range(0, 3));
      default: return 31'($urandom_range(0, 15));
    endcase
  endfunction

  function automatic req_t rand_request();
    return make_request(func_e'($urandom_range(0, 7)), mode_e'($urandom_range(0, 3)),
                        rand_operand(), mode_e'($urandom_range(0, 3)), rand_operand());
  endfunction

  // Stimulus.
  initial begin
    req_t rq;
    error_count = 0;
    results_seen = 0;
    queued_count = 0;
    send_idle_pct = 36;
    recv_idle_pct = 36;
    for (int i = 0; i < 4; i++) vm_regs[i] = '0;
    for (int i = 0; i < MemWords; i++) vm_mem[i] = '0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, every operation and mode, special cases.
    pending_requests.push_back(make_request(FN_MOV, MD_REG, 31'd0, MD_IMM, 31'h7fff_ffff));
    pending_requests.push_back(make_request(FN_NOT, MD_REG, 31'd1, MD_IMM, 31'd5));
    pending_requests.push_back(make_request(FN_ADD, MD_REG, 31'd0, MD_REG, 31'd1));
    pending_requests.push_back(make_request(FN_MOV, MD_DIR, 31'h7fff_ffff, MD_IMM, 31'd7));
    pending_requests.push_back(make_request(FN_MOV, MD_DIR, 31'd3, MD_IMM, 31'd1023));
    pending_requests.push_back(make_request(FN_MOV, MD_IND, 31'd3, MD_REG, 31'd1));
    pending_requests.push_back(make_request(FN_MUL, MD_REG, 31'd2, MD_IND, 31'h7fff_ffff));
    pending_requests.push_back(make_request(FN_SUB, MD_REG, 31'd2, MD_DIR, 31'd511));
    pending_requests.push_back(make_request(FN_AND, MD_REG, 31'd1, MD_IMM, 31'h5555_5555));
    pending_requests.push_back(make_request(FN_OR, MD_DIR, 31'd8, MD_REG, 31'd1));
    pending_requests.push_back(make_request(FN_DIV, MD_REG, 31'd1, MD_IMM, 31'd0));
    pending_requests.push_back(make_request(FN_DIV, MD_REG, 31'd1, MD_IMM, 31'd7));
    pending_requests.push_back(make_request(FN_DIV, MD_IMM, 31'd100, MD_IMM, 31'd7));
    pending_requests.push_back(make_request(FN_MOV, MD_REG, 31'd0, MD_IMM, 31'h4000_0000));
    pending_requests.push_back(make_request(FN_ADD, MD_REG, 31'd0, MD_REG, 31'd0));
    pending_requests.push_back(make_request(FN_NOT, MD_REG, 31'd2, MD_IMM, 31'd0));
    pending_requests.push_back(make_request(FN_MOV, MD_REG, 31'd2, MD_IMM, 31'd0));
    pending_requests.push_back(make_request(FN_NOT, MD_REG, 31'd2, MD_IMM, 31'd0));
    // Most negative divided by minus one.
    pending_requests.push_back(make_request(FN_DIV, MD_REG, 31'd0, MD_REG, 31'd2));
    pending_requests.push_back(make_request(FN_DIV, MD_REG, 31'd3, MD_IMM, 31'd3));
    pending_requests.push_back(make_request(FN_ADD, MD_IMM, 31'd9, MD_REG, 31'd1));
    pending_requests.push_back(make_request(FN_SUB, MD_IND, 31'd8, MD_IND, 31'd3));
    queued_count = pending_requests.size();

    // Hold off until every result is back, then randomize.
    wait (results_seen == queued_count);
    for (int i = 0; i < 1750; i++) begin
      if (i == 600) begin
        wait (pending_requests.size() == 0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (i == 900) begin
        wait (pending_requests.size() == 0);
        send_idle_pct = 36;
        recv_idle_pct = 36;
      end
      rq = rand_request();
      pending_requests.push_back(rq);
      queued_count++;
      if (pending_requests.size() > 8) wait (pending_requests.size() < 4);
    end
    wait (results_seen == queued_count);
    repeat (60) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Request driver.
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t rs;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        execute_instruction(in_data_i, rs);
        expected_states.push_back(rs);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_requests.size() > 0 &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i <= pending_requests.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor and stall generator.
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (expected_states.size() == 0) begin
          report_mismatch("unexpected result", 32'(out_data_o.divide_by_zero), 32'd0);
        end else begin
          want = expected_states.pop_front();
          if (out_data_o.reg_a !== want.reg_a)
            report_mismatch("reg_a", out_data_o.reg_a, want.reg_a);
          if (out_data_o.reg_b !== want.reg_b)
            report_mismatch("reg_b", out_data_o.reg_b, want.reg_b);
          if (out_data_o.reg_c !== want.reg_c)
            report_mismatch("reg_c", out_data_o.reg_c, want.reg_c);
          if (out_data_o.reg_d !== want.reg_d)
            report_mismatch("reg_d", out_data_o.reg_d, want.reg_d);
          if (out_data_o.divide_by_zero !== want.divide_by_zero)
            report_mismatch("divide_by_zero", 32'(out_data_o.divide_by_zero),
                            32'(want.divide_by_zero));
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

endmodule

@@ sim.f @@
src/tovm_pkg.sv
src/tovm_ctrl.sv
src/tovm_dp.sv
src/two_operand_vm_execute.sv
src/tovm_checker.sv
test/tb_two_operand_vm_execute.sv
